FILE: hw/rtl/usbmidi_pkg.sv
// Shared types, codes and the code index length table of the USB-MIDI receive queues.
package usbmidi_pkg;

	localparam int CHANNELS_DEF    = 4;
	localparam int QUEUE_DEPTH_DEF = 64;

	localparam logic OP_RECEIVE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	typedef enum logic [2:0] {
		ST_ACCEPTED   = 3'd0,
		ST_DROPPED    = 3'd1,
		ST_IGNORED    = 3'd2,
		ST_READ_OK    = 3'd3,
		ST_READ_EMPTY = 3'd4
	} rx_status_t;

	typedef struct packed {
		logic       op;
		logic [3:0] cable;
		logic [3:0] code_index;
		logic [7:0] payload_first;
		logic [7:0] payload_second;
		logic [7:0] payload_third;
		logic       transfer_error;
	} req_t;

	typedef struct packed {
		rx_status_t  status;
		logic [7:0]  read_byte;
		logic [6:0]  fill_level;
		logic [31:0] received_total;
		logic [31:0] dropped_total;
	} rsp_t;

	// payload bytes carried by each code index
	function automatic logic [1:0] payload_len(input logic [3:0] code);
		logic [1:0] len;
		unique case (code) inside
			4'h0, 4'h1:             len = 2'd0;
			4'h5, 4'hF:             len = 2'd1;
			4'h2, 4'h6, 4'hC, 4'hD: len = 2'd2;
			default:                len = 2'd3;
		endcase
		return len;
	endfunction

endpackage

FILE: hw/rtl/usbmidi_if.sv
// Valid/ready channel interfaces for request and response words.
interface usbmidi_req_if;
	import usbmidi_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface usbmidi_rsp_if;
	import usbmidi_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: hw/rtl/usb_midi_packet_receive_queues.sv
// USB-MIDI event packet receiver with per-channel byte queues and counters.
//
// req carries one word per item: op selects a packet receive or a one byte read;
// cable names the channel. rsp returns exactly one word per request word, in order.
// A receive looks up the payload length from the code index and either enqueues
// the whole packet, drops it (queue lacks room, drop counter grows) or ignores it
// (transfer error, zero length, cable beyond the channels). A read dequeues one
// byte or reports empty. Each packet occupies one entry of the packet memory;
// reads walk the bytes of the head entry.
// The response is registered and appears in the cycle after the request is
// accepted. One word per cycle is sustained while rsp takes each word, set by
// the single write and read port of the packet memory. A new request enters as the
// last response is taken; req.ready drops only while rsp is valid and not taken.
// Reset clears pointers, fill levels, counters and the response valid; the
// packet memory is not cleared, since an entry is always written before read.
module usb_midi_packet_receive_queues #(
	parameter int CHANNELS    = usbmidi_pkg::CHANNELS_DEF,
	parameter int QUEUE_DEPTH = usbmidi_pkg::QUEUE_DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	usbmidi_req_if.sink   req,
	usbmidi_rsp_if.source rsp
);
	import usbmidi_pkg::*;

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0] len;
		logic [7:0] b2;
		logic [7:0] b1;
		logic [7:0] b0;
	} entry_t;

	entry_t           mem [CHANNELS][QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_pkt_q [CHANNELS];
	logic [PTR_W-1:0] rd_pkt_q [CHANNELS];
	logic [1:0]       rd_off_q [CHANNELS];
	logic [OCC_W-1:0] occ_q    [CHANNELS];
	logic [31:0]      rcv_q    [CHANNELS];
	logic [31:0]      drp_q    [CHANNELS];

	logic            valid_s1;
	rsp_t            res_s1;
	entry_t          ent_s1;
	logic [1:0]      off_s1;
	logic [CH_W-1:0] ch_s1;
	logic            upd_q;

	logic             acc;
	logic             ch_ok;
	logic [CH_W-1:0]  ch;
	logic [1:0]       len;
	logic [OCC_W-1:0] occ;
	logic [OCC_W:0]   occ_sum;
	logic             full;
	logic             fold;
	logic [PTR_W-1:0] eff_pkt;
	logic [1:0]       eff_off;
	logic             do_rd;
	logic             do_wr;
	logic             do_drop;
	logic             rx_bad;
	logic [OCC_W-1:0] occ_new;
	logic [31:0]      rcv_new;
	logic [31:0]      drp_new;
	rsp_t             res_d;
	logic [7:0]       sel_byte;

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign acc       = req.valid && req.ready;
	assign req.ready = !valid_s1 || rsp.ready;

	assign ch_ok = {1'b0, req.payload.cable} < 5'(CHANNELS);
	assign ch    = req.payload.cable[CH_W-1:0];
	assign len   = payload_len(req.payload.code_index);
	assign occ   = occ_q[ch];

	assign occ_sum = (OCC_W + 1)'(occ) + (OCC_W + 1)'(len);
	assign full    = occ_sum > (OCC_W + 1)'(QUEUE_DEPTH);

	// pending head advance from the read accepted in the previous cycle
	assign fold    = upd_q && (ch_s1 == ch) && (rd_off_q[ch] == ent_s1.len);
	assign eff_pkt = fold ? nxt(rd_pkt_q[ch]) : rd_pkt_q[ch];
	assign eff_off = fold ? 2'd0 : rd_off_q[ch];

	assign rx_bad  = !ch_ok || req.payload.transfer_error || (len == 2'd0);
	assign do_rd   = acc && (req.payload.op == OP_READ) && ch_ok && (occ != '0);
	assign do_wr   = acc && (req.payload.op == OP_RECEIVE) && !rx_bad && !full;
	assign do_drop = acc && (req.payload.op == OP_RECEIVE) && !rx_bad && full;

	always_comb begin
		occ_new = occ;
		rcv_new = rcv_q[ch];
		drp_new = drp_q[ch];
		res_d   = '0;
		if (req.payload.op == OP_READ) begin
			if (ch_ok && (occ != '0)) begin
				res_d.status = ST_READ_OK;
				occ_new      = occ - 1'b1;
			end else begin
				res_d.status = ST_READ_EMPTY;
			end
		end else if (rx_bad) begin
			res_d.status = ST_IGNORED;
		end else if (full) begin
			res_d.status = ST_DROPPED;
			drp_new      = drp_q[ch] + 32'(len);
		end else begin
			res_d.status = ST_ACCEPTED;
			occ_new      = occ_sum[OCC_W-1:0];
			rcv_new      = rcv_q[ch] + 32'(len);
		end
		if (ch_ok) begin
			res_d.fill_level     = 7'(occ_new);
			res_d.received_total = rcv_new;
			res_d.dropped_total  = drp_new;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[ch][wr_pkt_q[ch]] <= '{len: len, b2: req.payload.payload_third,
				b1: req.payload.payload_second, b0: req.payload.payload_first};
		end
		if (acc) begin
			ent_s1 <= mem[ch][eff_pkt];
			off_s1 <= eff_off;
			res_s1 <= res_d;
			ch_s1  <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			upd_q    <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				wr_pkt_q[i] <= '0;
				rd_pkt_q[i] <= '0;
				rd_off_q[i] <= '0;
				occ_q[i]    <= '0;
				rcv_q[i]    <= '0;
				drp_q[i]    <= '0;
			end
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s1 <= 1'b0;
			end
			upd_q <= do_rd;
			for (int i = 0; i < CHANNELS; i++) begin
				if (do_wr && (ch == CH_W'(i))) begin
					wr_pkt_q[i] <= nxt(wr_pkt_q[i]);
					occ_q[i]    <= occ_new;
					rcv_q[i]    <= rcv_new;
				end
				if (do_drop && (ch == CH_W'(i))) begin
					drp_q[i] <= drp_new;
				end
				if (do_rd && (ch == CH_W'(i))) begin
					rd_pkt_q[i] <= eff_pkt;
					rd_off_q[i] <= eff_off + 1'b1;
					occ_q[i]    <= occ_new;
				end else if (upd_q && (ch_s1 == CH_W'(i)) && (rd_off_q[i] == ent_s1.len)) begin
					rd_pkt_q[i] <= nxt(rd_pkt_q[i]);
					rd_off_q[i] <= '0;
				end
			end
		end
	end

	always_comb begin
		case (off_s1)
			2'd0:    sel_byte = ent_s1.b0;
			2'd1:    sel_byte = ent_s1.b1;
			default: sel_byte = ent_s1.b2;
		endcase
	end

	always_comb begin
		rsp.payload           = res_s1;
		rsp.payload.read_byte = (res_s1.status == ST_READ_OK) ? sel_byte : 8'd0;
	end
	assign rsp.valid = valid_s1;

	a_upd_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		upd_q |-> $past(acc) && $past(req.payload.op == OP_READ))
		else $error("head update without a read the cycle before");

	a_byte_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.payload.status != ST_READ_OK) |-> rsp.payload.read_byte == 8'd0)
		else $error("read_byte nonzero on a word that is no successful read");

	a_ready_only_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid && !rsp.ready)
		else $error("request stalled while response side is free");

endmodule

FILE: test/tb_usb_midi_packet_receive_queues.sv
// Testbench for the USB-MIDI packet receive queues: predicting scoreboard, directed and random words.
module tb_usb_midi_packet_receive_queues;
	timeunit 1ns;
	timeprecision 1ps;

	import usbmidi_pkg::*;

	localparam int CHANNELS    = CHANNELS_DEF;
	localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
	localparam int PAYLOAD_BYTES [16] = '{0, 0, 2, 3, 3, 1, 2, 3, 3, 3, 3, 3, 2, 2, 3, 1};

	class midi_ring_tracker;
		logic [7:0] ring [CHANNELS][$];
		bit [31:0] rx_bytes [CHANNELS];
		bit [31:0] lost_bytes [CHANNELS];
		rsp_t expected_replies [$];
		int unsigned mismatches;

		function int unsigned outstanding();
			return expected_replies.size();
		endfunction

		// advance the ring and counter copy by one accepted word, queue its reply
		function void note_request(req_t w);
			rsp_t r;
			int n;
			int ch;
			r = '0;
			n = PAYLOAD_BYTES[w.code_index];
			ch = w.cable;
			if (w.cable >= CHANNELS) begin
				r.status = (w.op == OP_READ) ? ST_READ_EMPTY : ST_IGNORED;
			end else begin
				if (w.op == OP_READ) begin
					if (ring[ch].size() == 0) begin
						r.status = ST_READ_EMPTY;
					end else begin
						r.status = ST_READ_OK;
						r.read_byte = ring[ch].pop_front();
					end
				end else if (w.transfer_error || n == 0) begin
					r.status = ST_IGNORED;
				end else if (n > QUEUE_DEPTH - ring[ch].size()) begin
					r.status = ST_DROPPED;
					lost_bytes[ch] += n;
				end else begin
					ring[ch].push_back(w.payload_first);
					if (n > 1) ring[ch].push_back(w.payload_second);
					if (n > 2) ring[ch].push_back(w.payload_third);
					rx_bytes[ch] += n;
					r.status = ST_ACCEPTED;
				end
				r.fill_level = 7'(ring[ch].size());
				r.received_total = rx_bytes[ch];
				r.dropped_total = lost_bytes[ch];
			end
			expected_replies.push_back(r);
		endfunction

		function void check_reply(rsp_t got);
			rsp_t want;
			string bad;
			bad = "";
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("reply word with nothing expected: st=%0d byte=%h fill=%0d",
						got.status, got.read_byte, got.fill_level);
			end else begin
				want = expected_replies.pop_front();
				if (got.status !== want.status) bad = {bad, " status"};
				if (got.read_byte !== want.read_byte) bad = {bad, " read_byte"};
				if (got.fill_level !== want.fill_level) bad = {bad, " fill_level"};
				if (got.received_total !== want.received_total) bad = {bad, " received_total"};
				if (got.dropped_total !== want.dropped_total) bad = {bad, " dropped_total"};
				if (bad != "") begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("reply mismatch at %0t:%s", $realtime, bad);
						$display("  exp st=%0d byte=%h fill=%0d rx=%0d drop=%0d",
							want.status, want.read_byte, want.fill_level,
							want.received_total, want.dropped_total);
						$display("  got st=%0d byte=%h fill=%0d rx=%0d drop=%0d",
							got.status, got.read_byte, got.fill_level,
							got.received_total, got.dropped_total);
					end
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	midi_ring_tracker tracker;

	usbmidi_req_if req_bus();
	usbmidi_rsp_if rsp_bus();

	usb_midi_packet_receive_queues #(
		.CHANNELS(CHANNELS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic req_t make_req(input logic op, input logic [3:0] cable,
		input logic [3:0] code, input logic [7:0] first, input logic [7:0] second,
		input logic [7:0] third, input logic err);
		req_t w;
		w.op = op;
		w.cable = cable;
		w.code_index = code;
		w.payload_first = first;
		w.payload_second = second;
		w.payload_third = third;
		w.transfer_error = err;
		return w;
	endfunction

	// fill bursts push packets, drain bursts mostly read, noise covers all fields
	function automatic req_t random_word(input int unsigned mode, input int unsigned hot);
		req_t w;
		w.payload_first = 8'($urandom);
		w.payload_second = 8'($urandom);
		w.payload_third = 8'($urandom);
		w.code_index = 4'($urandom);
		w.transfer_error = ($urandom_range(31) == 0);
		w.cable = 4'(hot);
		if (mode < 3) begin
			w.op = ($urandom_range(9) < 9) ? OP_RECEIVE : OP_READ;
		end else if (mode < 8) begin
			w.op = ($urandom_range(19) < 19) ? OP_READ : OP_RECEIVE;
		end else begin
			w.op = 1'($urandom);
			w.cable = 4'($urandom);
			w.transfer_error = 1'($urandom);
		end
		return w;
	endfunction

	task automatic send_word(input req_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.payload <= w;
		do @(posedge clk); while (!req_bus.ready);
		tracker.note_request(w);
	endtask

	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		do @(posedge clk); while (tracker.outstanding() != 0);
	endtask

	task automatic run_directed();
		for (int code = 0; code < 16; code++)
			send_word(make_req(OP_RECEIVE, 4'd0, 4'(code), 8'(code * 17), 8'hFF - 8'(code),
				(code % 2) ? 8'h00 : 8'hFF, 1'b0));
		send_word(make_req(OP_RECEIVE, 4'd1, 4'd4, 8'h90, 8'h3C, 8'h7F, 1'b1));
		send_word(make_req(OP_RECEIVE, 4'd15, 4'd3, 8'hFF, 8'hFF, 8'hFF, 1'b0));
		send_word(make_req(OP_READ, 4'd4, 4'd0, 8'h00, 8'h00, 8'h00, 1'b0));
		send_word(make_req(OP_READ, 4'd3, 4'd15, 8'hFF, 8'hFF, 8'hFF, 1'b0));
		repeat (3) send_word(make_req(OP_READ, 4'd0, 4'd0, 8'h00, 8'h00, 8'h00, 1'b0));
		send_word(make_req(OP_RECEIVE, 4'd3, 4'd15, 8'hFF, 8'h00, 8'h00, 1'b0));
		send_word(make_req(OP_READ, 4'd3, 4'd0, 8'h00, 8'h00, 8'h00, 1'b0));
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned left;
		int unsigned burst;
		int unsigned hot;
		int unsigned mode;
		left = count;
		while (left > 0) begin
			mode = $urandom_range(9);
			hot = $urandom_range(CHANNELS - 1);
			if (mode < 3) burst = $urandom_range(30, 4);
			else if (mode < 8) burst = $urandom_range(60, 8);
			else burst = $urandom_range(6, 1);
			if (burst > left) burst = left;
			repeat (burst) send_word(random_word(mode, hot));
			if (mode < 8) left -= burst;
		end
	endtask

	// reply side: random stalls, check every word taken
	initial begin
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_bus.valid && rsp_bus.ready)
				tracker.check_reply(rsp_bus.payload);
			rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		tracker = new;
		send_idle_pct = 14;
		recv_idle_pct = 71;
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.payload <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_drained();
		run_random(380);
		wait_drained();
		send_idle_pct = 71;
		recv_idle_pct = 14;
		run_random(380);
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(390);
		wait_drained();
		repeat (5) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/usbmidi_pkg.sv
hw/rtl/usbmidi_if.sv
hw/rtl/usb_midi_packet_receive_queues.sv
test/tb_usb_midi_packet_receive_queues.sv
